/* hdl/scf_pkg.sv */
// Package for the servo command framer: frame layout, range limits and shared types.
// Used by the interfaces, the encoder, the serializer and the top level.
`timescale 1ns / 1ps

package scf_pkg;

    // Field widths
    localparam int CMD_W     = 5;
    localparam int VALUE_W   = 32;
    localparam int ID_W      = 7;
    localparam int BYTE_W    = 8;
    localparam int GROUP_W   = 7;
    localparam int NUM_GROUPS = 4;
    localparam int FRAME_MAX = NUM_GROUPS + 3;
    localparam int IDX_W     = $clog2(FRAME_MAX);

    // Signed range limits that pick the number of 7-bit groups
    localparam logic signed [VALUE_W-1:0] LIM3_HI = 32'sh000F_FFFF;
    localparam logic signed [VALUE_W-1:0] LIM3_LO = -32'sh0010_0000;
    localparam logic signed [VALUE_W-1:0] LIM2_HI = 32'sh0000_1FFF;
    localparam logic signed [VALUE_W-1:0] LIM2_LO = -32'sh0000_2000;
    localparam logic signed [VALUE_W-1:0] LIM1_HI = 32'sh0000_003F;
    localparam logic signed [VALUE_W-1:0] LIM1_LO = -32'sh0000_0040;

    // Bit 7 marks every byte after the device id
    localparam logic MARK_BIT = 1'b1;

    typedef logic [BYTE_W-1:0]  t_byte;
    typedef logic [GROUP_W-1:0] t_group;

    // One complete frame, byte 0 first; last_idx points at the checksum byte
    typedef struct packed {
        logic [FRAME_MAX-1:0][BYTE_W-1:0] bytes;
        logic [IDX_W-1:0]                 last_idx;
    } t_frame;

endpackage

/* hdl/scf_in_if.sv */
// Command channel: valid/ready with a command code and a signed value.
// Depends on scf_pkg for field widths.
`timescale 1ns / 1ps

interface scf_in_if;
    logic                               valid;
    logic                               ready;
    logic [scf_pkg::CMD_W-1:0]          command;
    logic signed [scf_pkg::VALUE_W-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

/* hdl/scf_out_if.sv */
// Transmit byte channel: valid/ready with one frame byte and an end-of-frame flag.
// Depends on scf_pkg for field widths.
`timescale 1ns / 1ps

interface scf_out_if;
    logic                       valid;
    logic                       ready;
    logic [scf_pkg::BYTE_W-1:0] tx_byte;
    logic                       last;

    modport source (output valid, output tx_byte, output last, input ready);
    modport sink   (input valid, input tx_byte, input last, output ready);
endinterface

/* hdl/scf_cfg_if.sv */
// Configuration write channel: valid/ready carrying the device id.
// Depends on scf_pkg for the id width.
`timescale 1ns / 1ps

interface scf_cfg_if;
    logic                     valid;
    logic                     ready;
    logic [scf_pkg::ID_W-1:0] drive_addr;

    modport source (output valid, output drive_addr, input ready);
    modport sink   (input valid, input drive_addr, output ready);
endinterface

/* hdl/scf_encoder.sv */
// Frame encoder: builds a whole frame from one command word in a single pass
// and holds it in a one-deep frame register. Depends on scf_pkg, scf_in_if, scf_cfg_if.
`timescale 1ns / 1ps

module scf_encoder (
    input  logic            i_clk,
    input  logic            i_rst_n,
    scf_in_if.sink          i_cmd,
    scf_cfg_if.sink         i_cfg,
    output scf_pkg::t_frame o_frame,
    output logic            o_frame_valid,
    input  logic            i_frame_take
);

    logic [scf_pkg::ID_W-1:0] r_drive_addr;
    logic                     r_valid;
    logic                     n_valid;
    scf_pkg::t_frame          r_frame;
    scf_pkg::t_frame          n_frame;

    logic [1:0]               grp_m1;
    scf_pkg::t_group          grp [scf_pkg::NUM_GROUPS];
    scf_pkg::t_group          csum;
    logic                     cmd_acc;

    // Device id register; writes are always taken
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_addr <= '0;
        end else if (i_cfg.valid) begin
            r_drive_addr <= i_cfg.drive_addr;
        end
    end

    // Group count minus one, from the signed range of the value
    always_comb begin
        if (i_cmd.value > scf_pkg::LIM3_HI || i_cmd.value < scf_pkg::LIM3_LO) begin
            grp_m1 = 2'd3;
        end else if (i_cmd.value > scf_pkg::LIM2_HI || i_cmd.value < scf_pkg::LIM2_LO) begin
            grp_m1 = 2'd2;
        end else if (i_cmd.value > scf_pkg::LIM1_HI || i_cmd.value < scf_pkg::LIM1_LO) begin
            grp_m1 = 2'd1;
        end else begin
            grp_m1 = 2'd0;
        end
    end

    // Frame bytes and checksum; mark bits drop out of a mod-128 sum
    always_comb begin
        for (int j = 0; j < scf_pkg::NUM_GROUPS; j++) begin
            grp[j] = i_cmd.value[j*scf_pkg::GROUP_W +: scf_pkg::GROUP_W];
        end

        csum = r_drive_addr + {grp_m1, i_cmd.command};
        for (int j = 0; j < scf_pkg::NUM_GROUPS; j++) begin
            if (2'(j) <= grp_m1) begin
                csum = csum + grp[j];
            end
        end

        n_frame.bytes[0] = {1'b0, r_drive_addr};
        n_frame.bytes[1] = {scf_pkg::MARK_BIT, grp_m1, i_cmd.command};
        // Positions 2..6: data groups high first, then the checksum, then filler
        for (int j = 0; j <= scf_pkg::NUM_GROUPS; j++) begin
            if (3'(j) <= {1'b0, grp_m1}) begin
                n_frame.bytes[2+j] = {scf_pkg::MARK_BIT, grp[2'(grp_m1 - 2'(j))]};
            end else if (3'(j) == {1'b0, grp_m1} + 3'd1) begin
                n_frame.bytes[2+j] = {scf_pkg::MARK_BIT, csum};
            end else begin
                n_frame.bytes[2+j] = '0;
            end
        end
        n_frame.last_idx = 3'd3 + {1'b0, grp_m1};
    end

    // One-deep frame register: refilled in the cycle it is handed on
    assign i_cmd.ready = !r_valid || i_frame_take;
    assign cmd_acc     = i_cmd.valid && i_cmd.ready;

    always_comb begin
        n_valid = r_valid;
        if (cmd_acc) begin
            n_valid = 1'b1;
        end else if (i_frame_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_acc) begin
            r_frame <= n_frame;
        end
    end

    assign o_frame       = r_frame;
    assign o_frame_valid = r_valid;

endmodule

/* hdl/scf_serializer.sv */
// Frame serializer: sends a held frame one byte per word through an output register.
// Depends on scf_pkg and scf_out_if.
`timescale 1ns / 1ps

module scf_serializer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  scf_pkg::t_frame i_frame,
    input  logic            i_frame_valid,
    output logic            o_frame_take,
    scf_out_if.source       o_tx
);

    scf_pkg::t_frame           r_frame;
    logic                      r_busy;
    logic                      n_busy;
    logic [scf_pkg::IDX_W-1:0] r_idx;
    logic [scf_pkg::IDX_W-1:0] n_idx;
    logic                      r_out_valid;
    logic                      n_out_valid;
    scf_pkg::t_byte            r_tx_byte;
    logic                      r_last;

    logic                      slot_free;
    logic                      at_end;

    // Output register can take a byte when empty or being drained
    assign slot_free    = !r_out_valid || o_tx.ready;
    assign at_end       = r_busy && (r_idx == r_frame.last_idx);
    assign o_frame_take = i_frame_valid && (!r_busy || (slot_free && at_end));

    // Control next state
    always_comb begin
        n_busy      = r_busy;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        if (slot_free) begin
            n_out_valid = r_busy;
            if (r_busy) begin
                n_idx = r_idx + 3'd1;
            end
            if (at_end) begin
                n_busy = 1'b0;
            end
        end
        if (o_frame_take) begin
            n_busy = 1'b1;
            n_idx  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (slot_free) begin
            r_tx_byte <= r_frame.bytes[r_idx];
            r_last    <= at_end;
        end
        if (o_frame_take) begin
            r_frame <= i_frame;
        end
    end

    assign o_tx.valid   = r_out_valid;
    assign o_tx.tx_byte = r_tx_byte;
    assign o_tx.last    = r_last;

endmodule

/* hdl/servo_command_framer.sv */
// Top level of the servo command framer: encoder followed by byte serializer.
// Depends on scf_pkg, scf_in_if, scf_out_if, scf_cfg_if, scf_encoder, scf_serializer.
`timescale 1ns / 1ps

// Each command word (5-bit code, signed 32-bit value) becomes one frame of 4 to 7
// bytes: device id, command byte, 1 to 4 data groups of 7 bits (high group first,
// chosen by signed range, bits above 27 dropped) and a checksum byte that carries
// last = 1. Bytes leave one per cycle while o_tx.ready is high. The first byte
// passes through the encoder frame register, the serializer frame register and
// the output register. One finished frame is held while the previous one is
// being sent, so the next command is taken without a gap and, while o_tx.ready
// is high, a stream of commands keeps the output busy every cycle. Write the
// device id only while no frame is pending; writes are always accepted.
module servo_command_framer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    scf_in_if.sink    i_cmd,
    scf_cfg_if.sink   i_cfg,
    scf_out_if.source o_tx
);

    scf_pkg::t_frame frame;
    logic            frame_valid;
    logic            frame_take;

    // Single-pass frame build into the holding register
    scf_encoder u_encoder (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (i_cmd),
        .i_cfg         (i_cfg),
        .o_frame       (frame),
        .o_frame_valid (frame_valid),
        .i_frame_take  (frame_take)
    );

    // Byte-at-a-time transmit
    scf_serializer u_serializer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame       (frame),
        .i_frame_valid (frame_valid),
        .o_frame_take  (frame_take),
        .o_tx          (o_tx)
    );

endmodule
